[rtl/ssr_pkg.sv]
package ssr_pkg;

  // Window depth and longest usable pattern; both are fixed by the register map.
  localparam int unsigned WIN_DEPTH   = 16;
  localparam int unsigned MAX_PATTERN = 16;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned DATA_W      = 64;

  localparam logic [2:0] REG_PAT_LO  = 3'd0;
  localparam logic [2:0] REG_PAT_HI  = 3'd1;
  localparam logic [2:0] REG_PAT_LEN = 3'd2;
  localparam logic [2:0] REG_REP_LO  = 3'd3;
  localparam logic [2:0] REG_REP_HI  = 3'd4;
  localparam logic [2:0] REG_REP_LEN = 3'd5;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] pat;
    logic [LEN_W-1:0]          plen;
    logic [WIN_DEPTH-1:0][7:0] rep;
    logic [LEN_W-1:0]          rlen;
    logic                      clr_fill;
  } ssr_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       last;
    logic       done;
  } ssr_res_t;

endpackage

[rtl/ssr_cfg.sv]
module ssr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssr_pkg::DATA_W-1:0]  pwdata,
  output logic [ssr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ssr_pkg::ssr_cfg_t           cfg_o
);

  logic [63:0] pat_lo_q, pat_lo_d, pat_hi_q, pat_hi_d;
  logic [63:0] rep_lo_q, rep_lo_d, rep_hi_q, rep_hi_d;
  logic [ssr_pkg::LEN_W-1:0] plen_q, plen_d, rlen_q, rlen_d;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       plen_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;
  assign plen_wr = wr_en && (reg_idx == ssr_pkg::REG_PAT_LEN);

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    plen_d   = plen_q;
    rep_lo_d = rep_lo_q;
    rep_hi_d = rep_hi_q;
    rlen_d   = rlen_q;
    if (wr_en) begin
      case (reg_idx)
        ssr_pkg::REG_PAT_LO:  pat_lo_d = pwdata;
        ssr_pkg::REG_PAT_HI:  pat_hi_d = pwdata;
        ssr_pkg::REG_PAT_LEN: plen_d   = pwdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REP_LO:  rep_lo_d = pwdata;
        ssr_pkg::REG_REP_HI:  rep_hi_d = pwdata;
        ssr_pkg::REG_REP_LEN: rlen_d   = pwdata[ssr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= '0;
      rep_lo_q <= '0;
      rep_hi_q <= '0;
      rlen_q   <= '0;
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      plen_q   <= plen_d;
      rep_lo_q <= rep_lo_d;
      rep_hi_q <= rep_hi_d;
      rlen_q   <= rlen_d;
    end
  end

  always_comb begin
    case (reg_idx)
      ssr_pkg::REG_PAT_LO:  prdata = pat_lo_q;
      ssr_pkg::REG_PAT_HI:  prdata = pat_hi_q;
      ssr_pkg::REG_PAT_LEN: prdata = {{(ssr_pkg::DATA_W-ssr_pkg::LEN_W){1'b0}}, plen_q};
      ssr_pkg::REG_REP_LO:  prdata = rep_lo_q;
      ssr_pkg::REG_REP_HI:  prdata = rep_hi_q;
      ssr_pkg::REG_REP_LEN: prdata = {{(ssr_pkg::DATA_W-ssr_pkg::LEN_W){1'b0}}, rlen_q};
      default:              prdata = '0;
    endcase
  end

  // Lengths above the window depth saturate to the window depth.
  always_comb begin
    cfg_o.pat      = {pat_hi_q, pat_lo_q};
    cfg_o.rep      = {rep_hi_q, rep_lo_q};
    cfg_o.plen     = (plen_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN))
                     ? ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN) : plen_q;
    cfg_o.rlen     = (rlen_q > ssr_pkg::LEN_W'(ssr_pkg::WIN_DEPTH))
                     ? ssr_pkg::LEN_W'(ssr_pkg::WIN_DEPTH) : rlen_q;
    cfg_o.clr_fill = plen_wr;
  end

endmodule

[rtl/ssr_win_cell.sv]
module ssr_win_cell (
  input  logic       clk_i,
  input  logic       wr_i,
  input  logic       shift_i,
  input  logic [7:0] text_i,
  input  logic [7:0] nbr_i,
  input  logic [7:0] pat_i,
  output logic [7:0] cur_o,
  output logic       eq_o
);

  logic [7:0] byte_q, byte_d;

  // cur_o is the cell content with this cycle's byte already written in.
  assign cur_o  = wr_i ? text_i : byte_q;
  assign eq_o   = (cur_o == pat_i);
  assign byte_d = shift_i ? nbr_i : cur_o;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

[rtl/ssr_out_cell.sv]
module ssr_out_cell (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic              shift_i,
  input  ssr_pkg::ssr_res_t load_data_i,
  input  ssr_pkg::ssr_res_t nbr_i,
  output ssr_pkg::ssr_res_t res_o
);

  ssr_pkg::ssr_res_t res_q, res_d;

  always_comb begin
    if (load_i) begin
      res_d = load_data_i;
    end else if (shift_i) begin
      res_d = nbr_i;
    end else begin
      res_d = res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[rtl/stream_search_replace.sv]
// Streaming search and replace over a byte stream, non-overlapping matches.
// Input channel: text_byte_i/end_of_text_i with in_valid_i, back-pressured by
// in_stall_o. Output channel: out_byte_o, byte_valid_o, run_last_o and
// text_done_o with out_valid_o, back-pressured by out_stall_i.
// Configuration goes through the APB port; each register sits at 8*index.
// A row of window cells holds the last bytes and compares them with the
// pattern in parallel. The results of one item are loaded at once into a
// row of output cells that shifts toward an output register.
// The first result of an item passes through the output row and then the output register.
// Throughput: one item per cycle while each item gives at most one result and
// out_stall_i is low; an item that gives k results holds the output row until
// the single output port has drained them, one result per cycle while unstalled.
// While out_stall_i is high, the output register holds its result and, if the
// output row is empty, the block still accepts one more item into it, then stalls input.
// Reset clears configuration, window fill and output valid state; a write
// to pattern_length empties the window.
module stream_search_replace (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssr_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssr_pkg::DATA_W-1:0]  pwdata,
  output logic [ssr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        end_of_text_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        run_last_o,
  output logic                        text_done_o
);

  localparam int unsigned D = ssr_pkg::WIN_DEPTH;

  ssr_pkg::ssr_cfg_t cfg;

  ssr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [ssr_pkg::LEN_W-1:0] fill_q, fill_d, fill_new, n_res;
  logic [ssr_pkg::POS_W-1:0] pos;
  logic                      accept, len_zero, full, all_eq, hit, win_shift, marker;
  logic [D-1:0]              cell_wr, cell_eq, in_use;
  logic [D-1:0][7:0]         win_cur, win_nbr;

  assign accept   = in_valid_i & ~in_stall_o;
  assign len_zero = (cfg.plen == '0);
  assign pos      = (len_zero || fill_q >= cfg.plen) ? '0 : fill_q[ssr_pkg::POS_W-1:0];
  assign fill_new = {1'b0, pos} + ssr_pkg::LEN_W'(1);
  assign full     = len_zero || (fill_new == cfg.plen);
  assign all_eq   = &(cell_eq | ~in_use);
  assign hit      = ~len_zero & full & all_eq;
  assign win_shift = accept & ~len_zero & full & ~hit & ~end_of_text_i;

  for (genvar i = 0; i < D; i++) begin : g_win
    assign in_use[i]  = (ssr_pkg::LEN_W'(i) < cfg.plen);
    assign cell_wr[i] = accept && (pos == ssr_pkg::POS_W'(i));
    if (i == D - 1) begin : g_tail
      assign win_nbr[i] = 8'h00;
    end else begin : g_mid
      assign win_nbr[i] = win_cur[i+1];
    end
    ssr_win_cell u_cell (
      .clk_i   (clk_i),
      .wr_i    (cell_wr[i]),
      .shift_i (win_shift),
      .text_i  (text_byte_i),
      .nbr_i   (win_nbr[i]),
      .pat_i   (cfg.pat[i]),
      .cur_o   (win_cur[i]),
      .eq_o    (cell_eq[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (cfg.clr_fill) begin
      fill_d = '0;
    end else if (accept) begin
      if (len_zero || hit || end_of_text_i) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = fill_new - ssr_pkg::LEN_W'(1);
      end else begin
        fill_d = fill_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Result run of the current item.
  always_comb begin
    if (hit) begin
      n_res = cfg.rlen;
    end else if (end_of_text_i) begin
      n_res = fill_new;
    end else if (full) begin
      n_res = ssr_pkg::LEN_W'(1);
    end else begin
      n_res = '0;
    end
  end

  // An end of text whose item gives no result byte (a match with an empty replacement) gives a single end marker.
  assign marker = end_of_text_i && (n_res == '0);

  ssr_pkg::ssr_res_t [D-1:0] entry, oc_res, oc_nbr;

  for (genvar j = 0; j < D; j++) begin : g_entry
    always_comb begin
      entry[j].data   = hit ? cfg.rep[j] : win_cur[j];
      entry[j].bvalid = 1'b1;
      entry[j].last   = (ssr_pkg::LEN_W'(j + 1) == n_res);
      entry[j].done   = (ssr_pkg::LEN_W'(j + 1) == n_res) && end_of_text_i;
      if (j == 0 && marker) begin
        entry[j].data   = 8'h00;
        entry[j].bvalid = 1'b0;
        entry[j].last   = 1'b1;
        entry[j].done   = 1'b1;
      end
    end
  end

  // Output row and output register.
  logic [ssr_pkg::LEN_W-1:0] cnt_q, cnt_d;
  logic                      oreg_v_q, oreg_v_d, move, can_load, load;
  ssr_pkg::ssr_res_t         oreg_q;

  assign move       = (cnt_q != '0) && (!oreg_v_q || !out_stall_i);
  assign can_load   = (cnt_q == '0) || ((cnt_q == ssr_pkg::LEN_W'(1)) && move);
  assign in_stall_o = ~can_load;
  assign load       = accept && ((n_res != '0) || marker);

  for (genvar j = 0; j < D; j++) begin : g_out
    if (j == D - 1) begin : g_tail
      assign oc_nbr[j] = '0;
    end else begin : g_mid
      assign oc_nbr[j] = oc_res[j+1];
    end
    ssr_out_cell u_ocell (
      .clk_i       (clk_i),
      .load_i      (load),
      .shift_i     (move),
      .load_data_i (entry[j]),
      .nbr_i       (oc_nbr[j]),
      .res_o       (oc_res[j])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = marker ? ssr_pkg::LEN_W'(1) : n_res;
    end else if (move) begin
      cnt_d = cnt_q - ssr_pkg::LEN_W'(1);
    end
  end

  always_comb begin
    oreg_v_d = oreg_v_q;
    if (move) begin
      oreg_v_d = 1'b1;
    end else if (oreg_v_q && !out_stall_i) begin
      oreg_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      oreg_v_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      oreg_v_q <= oreg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      oreg_q <= oc_res[0];
    end
  end

  assign out_valid_o  = oreg_v_q;
  assign out_byte_o   = oreg_q.data;
  assign byte_valid_o = oreg_q.bvalid;
  assign run_last_o   = oreg_q.last;
  assign text_done_o  = oreg_q.done;

endmodule

[rtl/ssr_checker.sv]
module ssr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [7:0]                  out_byte_o,
  input logic                        byte_valid_o,
  input logic                        run_last_o,
  input logic                        text_done_o
);

  // A stalled result keeps its valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(byte_valid_o)
      && $stable(run_last_o) && $stable(text_done_o))
    else $error("result changed while stalled");

  // The final result of a text also closes its run.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_done_o |-> run_last_o)
    else $error("text end without run end");

  // An empty end marker only appears as the final result of a text.
  a_marker_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> run_last_o && text_done_o && (out_byte_o == 8'h00))
    else $error("malformed end marker");

endmodule

bind stream_search_replace ssr_checker u_ssr_checker (.*);
